// File: sv/cws_pkg.sv
// ---------------------------------------------------------------------------
// cws_pkg: shared types and constants of the comment and whitespace stripper
// Holds the result word layout, the fixed byte codes and the register map.
// ---------------------------------------------------------------------------
package cws_pkg;

   localparam logic [7:0] NL_BYTE = 8'h0A;
   localparam logic [7:0] SP_BYTE = 8'h20;

   localparam logic [1:0] CSR_COMMENT_CHAR = 2'd0;
   localparam logic [1:0] CSR_QUOTE_CHAR   = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_CHAR  = 2'd2;

   localparam logic [7:0] COMMENT_CHAR_RST = 8'd35;
   localparam logic [7:0] QUOTE_CHAR_RST   = 8'd34;
   localparam logic [7:0] ESCAPE_CHAR_RST  = 8'd92;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       stream_end;
   } rsp_word_type;

endpackage

// File: sv/comment_whitespace_stripper_core.sv
// ---------------------------------------------------------------------------
// comment_whitespace_stripper_core: byte stream comment and space compactor
// Drops comments, squeezes spaces and newlines outside quotes and passes
// quoted strings through, with a two word result buffer.
// ---------------------------------------------------------------------------
// One input word is accepted per cycle and its results are decided in the
// same cycle and loaded into a two word result buffer. Most words give zero
// or one result, so the block runs at one word per cycle while rsp_stall
// is low. A word that gives two results fills the buffer, and the input
// then stalls while the first result drains. A word with req_in_last set
// ends the stream and always gives at least one result.
module comment_whitespace_stripper_core
   import cws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_stream_end,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]   comment_char_ff;
   logic [7:0]   quote_char_ff;
   logic [7:0]   escape_char_ff;

   logic         in_comment_ff, in_comment_in;
   logic         in_quote_ff, in_quote_in;
   logic         after_escape_ff, after_escape_in;
   logic [7:0]   last_kept_ff, last_kept_in;
   logic         any_kept_ff, any_kept_in;
   logic         space_held_ff, space_held_in;

   rsp_word_type buf0_ff, buf0_in;
   rsp_word_type buf1_ff, buf1_in;
   logic [1:0]   count_ff, count_in;

   logic         req_accept;
   logic         rsp_accept;
   logic         keep;
   logic         drop_space;
   logic         flush_held;
   logic         put_byte;
   logic         put_final;
   logic         held_after;
   logic [1:0]   n_res;
   rsp_word_type res0;
   rsp_word_type res1;

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (count_ff == 2'd2) || ((count_ff == 2'd1) && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign rsp_out_byte   = buf0_ff.out_byte;
   assign rsp_byte_valid = buf0_ff.byte_valid;
   assign rsp_run_last   = buf0_ff.run_last;
   assign rsp_stream_end = buf0_ff.stream_end;

   always_comb begin
      in_comment_in   = in_comment_ff;
      in_quote_in     = in_quote_ff;
      after_escape_in = after_escape_ff;
      keep            = 1'b0;
      drop_space      = 1'b0;

      if (in_comment_ff) begin
         if (req_in_byte == NL_BYTE) begin
            in_comment_in = 1'b0;
         end
      end else if (after_escape_ff) begin
         keep            = 1'b1;
         after_escape_in = 1'b0;
      end else if (in_quote_ff) begin
         keep = 1'b1;
         if (req_in_byte == escape_char_ff) begin
            after_escape_in = 1'b1;
         end else if (req_in_byte == quote_char_ff) begin
            in_quote_in = 1'b0;
         end
      end else if (req_in_byte == comment_char_ff) begin
         in_comment_in = 1'b1;
      end else if (req_in_byte == quote_char_ff) begin
         keep        = 1'b1;
         in_quote_in = 1'b1;
      end else if ((req_in_byte != NL_BYTE && req_in_byte != SP_BYTE) || !any_kept_ff ||
                   last_kept_ff != req_in_byte) begin
         drop_space = (req_in_byte == NL_BYTE) && any_kept_ff && (last_kept_ff == SP_BYTE);
         keep = !((req_in_byte == SP_BYTE) && any_kept_ff && (last_kept_ff == NL_BYTE));
      end

      flush_held = keep && space_held_ff && !drop_space;
      put_byte   = keep && (req_in_byte != SP_BYTE);
      held_after = keep ? (req_in_byte == SP_BYTE) : space_held_ff;
      put_final  = req_in_last && held_after;

      n_res = {1'b0, flush_held} + {1'b0, put_byte} + {1'b0, put_final};
      if (req_in_last && n_res == 2'd0) begin
         n_res = 2'd1;
      end

      res0 = '0;
      res1 = '0;
      if (flush_held || put_final) begin
         res0.out_byte   = SP_BYTE;
         res0.byte_valid = 1'b1;
      end else if (put_byte) begin
         res0.out_byte   = req_in_byte;
         res0.byte_valid = 1'b1;
      end
      if (flush_held && put_byte) begin
         res1.out_byte   = req_in_byte;
         res1.byte_valid = 1'b1;
      end else begin
         res1.out_byte   = SP_BYTE;
         res1.byte_valid = 1'b1;
      end
      if (n_res == 2'd2) begin
         res1.run_last   = 1'b1;
         res1.stream_end = req_in_last;
      end else begin
         res0.run_last   = 1'b1;
         res0.stream_end = req_in_last;
      end

      last_kept_in  = keep ? req_in_byte : last_kept_ff;
      any_kept_in   = any_kept_ff || keep;
      space_held_in = held_after;
      if (req_in_last) begin
         in_comment_in   = 1'b0;
         in_quote_in     = 1'b0;
         after_escape_in = 1'b0;
         last_kept_in    = '0;
         any_kept_in     = 1'b0;
         space_held_in   = 1'b0;
      end

      // The input is only taken when the buffer is empty after this cycle's pop.
      buf0_in  = buf0_ff;
      buf1_in  = buf1_ff;
      count_in = count_ff;
      if (req_accept) begin
         buf0_in  = res0;
         buf1_in  = res1;
         count_in = n_res;
      end else if (rsp_accept) begin
         buf0_in  = buf1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_char_ff <= COMMENT_CHAR_RST;
         quote_char_ff   <= QUOTE_CHAR_RST;
         escape_char_ff  <= ESCAPE_CHAR_RST;
         in_comment_ff   <= 1'b0;
         in_quote_ff     <= 1'b0;
         after_escape_ff <= 1'b0;
         last_kept_ff    <= '0;
         any_kept_ff     <= 1'b0;
         space_held_ff   <= 1'b0;
         count_ff        <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COMMENT_CHAR: comment_char_ff <= csr_wr_data;
               CSR_QUOTE_CHAR:   quote_char_ff   <= csr_wr_data;
               CSR_ESCAPE_CHAR:  escape_char_ff  <= csr_wr_data;
               default: ;
            endcase
         end
         if (req_accept) begin
            in_comment_ff   <= in_comment_in;
            in_quote_ff     <= in_quote_in;
            after_escape_ff <= after_escape_in;
            last_kept_ff    <= last_kept_in;
            any_kept_ff     <= any_kept_in;
            space_held_ff   <= space_held_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> req_stall)
      else $error("input taken while result buffer is full");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_in_last) |=> (!in_quote_ff && !space_held_ff && !any_kept_ff))
      else $error("stream state not cleared after end word");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_end) |-> rsp_run_last)
      else $error("stream end on a word that is not the last of its run");

   a_bare_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_stream_end && rsp_out_byte == 8'd0))
      else $error("bare result outside stream end");

endmodule
